/* rtl/prefix_expression_evaluator_core_macros.svh */
// Assertion macros for the prefix expression evaluator top level.
`ifndef PREFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`define PREFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define PEXP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pexp assertion failed");
`define PEXP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pexp assertion failed");
`else
`define PEXP_ASSERT_IMP(lbl, ante, cons)
`define PEXP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/pexp_pkg.sv */
// Shared codes, character constants and types of the prefix expression evaluator.
package pexp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIV_ZERO  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Request to an iterative arithmetic unit.
    typedef struct packed {
        logic start;
        logic frac_shift;
        logic neg;
    } t_unit_req;

    function automatic logic f_is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

endpackage

/* rtl/pexp_stack.sv */
// Value stack storage: one write port and one registered read port.
module pexp_stack #(
    parameter int DEPTH = 32,
    parameter int W     = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/pexp_mul.sv */
// Shift-and-add multiplier on magnitudes with optional fraction shift and saturation.
module pexp_mul import pexp_pkg::*; #(
    parameter int W    = 48,
    parameter int FRAC = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_unit_req           i_req,
    input  logic [W-1:0]        i_a,
    input  logic [W-1:0]        i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_result
);

    localparam int CW = $clog2(W + 1);
    localparam logic [2*W-1:0] POS_LIM = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [2*W-1:0] NEG_LIM = POS_LIM + (2*W)'(1);

    logic                r_busy, r_fin, r_done, r_shift, r_neg;
    logic [CW-1:0]       r_cnt;
    logic [2*W-1:0]      r_acc, r_mcand;
    logic [W-1:0]        r_mplier;
    logic signed [W-1:0] r_result;
    logic [2*W-1:0]      shifted;
    logic [W-1:0]        sat_mag;

    always_comb begin
        shifted = r_shift ? (r_acc >> FRAC) : r_acc;
        if (r_neg) begin
            sat_mag = (shifted > NEG_LIM) ? NEG_LIM[W-1:0] : shifted[W-1:0];
        end else begin
            sat_mag = (shifted > POS_LIM) ? POS_LIM[W-1:0] : shifted[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= CW'(W);
                r_acc    <= '0;
                r_mcand  <= {{W{1'b0}}, i_a};
                r_mplier <= i_b;
                r_shift  <= i_req.frac_shift;
                r_neg    <= i_req.neg;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin    <= 1'b0;
                r_done   <= 1'b1;
                r_result <= r_neg ? signed'(W'(0) - sat_mag) : signed'(sat_mag);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/pexp_div.sv */
// Restoring divider on magnitudes, one quotient bit per cycle, with saturation.
module pexp_div import pexp_pkg::*; #(
    parameter int W    = 48,
    parameter int FRAC = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_unit_req           i_req,
    input  logic [W-1:0]        i_num,
    input  logic [W-1:0]        i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_result
);

    localparam int N  = W + FRAC;
    localparam int CW = $clog2(N + 1);
    localparam logic [N-1:0] POS_LIM = {{(FRAC + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [N-1:0] NEG_LIM = POS_LIM + N'(1);

    logic                r_busy, r_fin, r_done, r_neg;
    logic [CW-1:0]       r_cnt;
    logic [N-1:0]        r_num, r_q;
    logic [W-1:0]        r_rem, r_den;
    logic signed [W-1:0] r_result;
    logic [W:0]          rem_sh, diff;
    logic                ge;
    logic [W-1:0]        sat_mag;

    always_comb begin
        rem_sh = {r_rem, r_num[N-1]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
        if (r_neg) begin
            sat_mag = (r_q > NEG_LIM) ? NEG_LIM[W-1:0] : r_q[W-1:0];
        end else begin
            sat_mag = (r_q > POS_LIM) ? POS_LIM[W-1:0] : r_q[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
                r_neg  <= i_req.neg;
                r_num  <= i_req.frac_shift ? {i_num, {FRAC{1'b0}}} : {{FRAC{1'b0}}, i_num};
            end else if (r_busy) begin
                r_rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
                r_q   <= {r_q[N-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin    <= 1'b0;
                r_done   <= 1'b1;
                r_result <= r_neg ? signed'(W'(0) - sat_mag) : signed'(sat_mag);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/prefix_expression_evaluator_core.sv */
// Top level of the prefix expression evaluator: sequencer, number builder and value stack.
//
// Usage: characters of a prefix expression enter on the input channel (i_ch, i_last),
// last character first; the transfer carrying i_last = 1 ends the expression. That
// transfer, and only that one, yields one result transfer on o_value and o_status.
// The block works on one character at a time and raises o_stall while busy:
//   separators and '+'/'-' inside a number use neither arithmetic unit,
//   a digit waits for the serial multiplier (one bit a cycle),
//   '*' waits for the multiplier after two stack pops,
//   '.' waits for the serial divider and '/' (but for division by zero) waits for the
//   divider after two stack pops (one quotient bit a cycle),
//   the ending character adds the final push and top-of-stack read,
//   and more while the result register still holds a result the receiver stalls.
// The stack lives in a synchronous memory with one registered read port, so each pop
// goes through a read state and then a capture state.
// The result sits in an output register; the next expression may start while it
// waits, but an ending character holds in its emit step until the register is free.
// Reset (synchronous, active low) empties the stack, clears the pending number and
// the error status, and drops any undelivered result. After a result is emitted the
// evaluation state returns to its reset values.
module prefix_expression_evaluator_core import pexp_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_ch,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic [1:0]                    o_status
);

`include "prefix_expression_evaluator_core_macros.svh"

    localparam int W    = VALUE_WIDTH;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_WAIT, S_DIV_WAIT, S_NUM_PUSH, S_POP_RD, S_POP_CAP, S_EXEC,
        S_RES_PUSH, S_FINISH, S_END_PUSH, S_TOP_RD, S_TOP_CAP, S_EMIT
    } t_state;

    // Saturating add and subtract on signed values of the stack width.
    function automatic logic signed [W-1:0] f_sat_add(input logic signed [W-1:0] a,
                                                      input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? ~MAXV : MAXV;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_sat_sub(input logic signed [W-1:0] a,
                                                      input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? ~MAXV : MAXV;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] a);
        logic [W-1:0] u;
        u = a;
        return a[W-1] ? (~u + W'(1)) : u;
    endfunction

    t_state              r_state;
    logic [7:0]          r_ch;
    logic                r_last;
    logic [CNTW-1:0]     r_count;
    logic signed [W-1:0] r_accum;
    logic [W-1:0]        r_place;
    logic                r_in_num;
    t_status             r_err;
    logic signed [W-1:0] r_lhs, r_rhs, r_res;
    logic                r_pop_second;
    logic                r_to_accum;
    t_unit_req           r_mul_req, r_div_req;
    logic [W-1:0]        r_op_a, r_op_b;
    logic                r_out_valid;
    logic signed [W-1:0] r_out_value;
    t_status             r_out_status;

    logic                is_digit;
    logic [W+4:0]        d_wide;
    logic [W-1:0]        d_val;
    logic [W+3:0]        p10_wide;
    logic [W-1:0]        place10;
    logic                stack_full;
    logic                wr_en;
    logic [W-1:0]        wr_data;
    logic [CNTW-1:0]     cnt_m1;
    logic [W-1:0]        rd_data;
    logic                mul_done, div_done;
    logic signed [W-1:0] mul_res, div_res;

    // Digit weight (digit << FRAC_BITS, clamped) and the next decimal place.
    always_comb begin
        is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        d_wide   = (W + 5)'(i_ch[3:0]) << FRAC_BITS;
        d_val    = (d_wide > (W + 5)'(MAXV)) ? MAXV : d_wide[W-1:0];
        p10_wide = {4'b0, r_place} * (W + 4)'(DEC_BASE);
        place10  = (p10_wide > (W + 4)'(MAXV)) ? MAXV : p10_wide[W-1:0];
    end

    // Stack port control follows the sequencer state.
    always_comb begin
        stack_full = r_count == CNTW'(STACK_DEPTH);
        wr_en      = (((r_state == S_NUM_PUSH) || (r_state == S_END_PUSH)) && r_in_num
                      || (r_state == S_RES_PUSH)) && !stack_full;
        wr_data    = (r_state == S_RES_PUSH) ? r_res : r_accum;
        cnt_m1     = r_count - CNTW'(1);
    end

    assign o_stall = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_accum      <= '0;
            r_place      <= W'(1);
            r_in_num     <= 1'b0;
            r_err        <= ST_OK;
            r_mul_req    <= '0;
            r_div_req    <= '0;
            r_out_valid  <= 1'b0;
            r_pop_second <= 1'b0;
            r_to_accum   <= 1'b0;
        end else begin
            r_mul_req <= '0;
            r_div_req <= '0;
            // The emit step reloads the output register itself.
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ch         <= i_ch;
                        r_last       <= i_last;
                        r_pop_second <= 1'b0;
                        if (is_digit) begin
                            r_in_num   <= 1'b1;
                            r_op_a     <= d_val;
                            r_op_b     <= r_place;
                            r_place    <= place10;
                            r_to_accum <= 1'b1;
                            r_mul_req  <= '{start: 1'b1, frac_shift: 1'b0, neg: 1'b0};
                            r_state    <= S_MUL_WAIT;
                        end else if (i_ch == CH_DOT) begin
                            r_in_num   <= 1'b1;
                            r_op_a     <= f_mag(r_accum);
                            r_op_b     <= r_place;
                            r_to_accum <= 1'b1;
                            r_div_req  <= '{start: 1'b1, frac_shift: 1'b0, neg: r_accum[W-1]};
                            r_state    <= S_DIV_WAIT;
                        end else if (r_in_num && (i_ch == CH_MINUS)) begin
                            r_accum <= f_sat_sub('0, r_accum);
                            r_state <= S_FINISH;
                        end else if (r_in_num && (i_ch == CH_PLUS)) begin
                            r_state <= S_FINISH;
                        end else if (r_in_num) begin
                            r_state <= S_NUM_PUSH;
                        end else begin
                            r_state <= f_is_op(i_ch) ? S_POP_RD : S_FINISH;
                        end
                    end
                end
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        if (r_to_accum) begin
                            r_accum <= f_sat_add(r_accum, mul_res);
                            r_state <= S_FINISH;
                        end else begin
                            r_res   <= mul_res;
                            r_state <= S_RES_PUSH;
                        end
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_to_accum) begin
                            r_accum <= div_res;
                            r_place <= W'(1);
                            r_state <= S_FINISH;
                        end else begin
                            r_res   <= div_res;
                            r_state <= S_RES_PUSH;
                        end
                    end
                end
                S_NUM_PUSH: begin
                    if (stack_full) begin
                        if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                    end else begin
                        r_count <= r_count + CNTW'(1);
                    end
                    r_accum  <= '0;
                    r_place  <= W'(1);
                    r_in_num <= 1'b0;
                    r_state  <= f_is_op(r_ch) ? S_POP_RD : S_FINISH;
                end
                S_POP_RD: begin
                    // The memory sees address count - 1 in this cycle.
                    if (r_count == '0) begin
                        if (r_err == ST_OK) r_err <= ST_UNDERFLOW;
                        if (r_pop_second) begin
                            r_rhs   <= '0;
                            r_state <= S_EXEC;
                        end else begin
                            r_lhs        <= '0;
                            r_pop_second <= 1'b1;
                        end
                    end else begin
                        r_count <= cnt_m1;
                        r_state <= S_POP_CAP;
                    end
                end
                S_POP_CAP: begin
                    if (r_pop_second) begin
                        r_rhs   <= rd_data;
                        r_state <= S_EXEC;
                    end else begin
                        r_lhs        <= rd_data;
                        r_pop_second <= 1'b1;
                        r_state      <= S_POP_RD;
                    end
                end
                S_EXEC: begin
                    r_to_accum <= 1'b0;
                    r_op_a     <= f_mag(r_lhs);
                    r_op_b     <= f_mag(r_rhs);
                    case (r_ch)
                        CH_PLUS: begin
                            r_res   <= f_sat_add(r_lhs, r_rhs);
                            r_state <= S_RES_PUSH;
                        end
                        CH_MINUS: begin
                            r_res   <= f_sat_sub(r_lhs, r_rhs);
                            r_state <= S_RES_PUSH;
                        end
                        CH_STAR: begin
                            r_mul_req <= '{start: 1'b1, frac_shift: 1'b1,
                                           neg: r_lhs[W-1] ^ r_rhs[W-1]};
                            r_state   <= S_MUL_WAIT;
                        end
                        CH_SLASH: begin
                            if (r_rhs == '0) begin
                                if (r_err == ST_OK) r_err <= ST_DIV_ZERO;
                                r_res   <= '0;
                                r_state <= S_RES_PUSH;
                            end else begin
                                r_div_req <= '{start: 1'b1, frac_shift: 1'b1,
                                               neg: r_lhs[W-1] ^ r_rhs[W-1]};
                                r_state   <= S_DIV_WAIT;
                            end
                        end
                        default: r_state <= S_FINISH;
                    endcase
                end
                S_RES_PUSH: begin
                    if (stack_full) begin
                        if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                    end else begin
                        r_count <= r_count + CNTW'(1);
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= r_last ? S_END_PUSH : S_IDLE;
                end
                S_END_PUSH: begin
                    if (r_in_num) begin
                        if (stack_full) begin
                            if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                        end else begin
                            r_count <= r_count + CNTW'(1);
                        end
                    end
                    r_accum  <= '0;
                    r_place  <= W'(1);
                    r_in_num <= 1'b0;
                    r_state  <= S_TOP_RD;
                end
                S_TOP_RD: begin
                    if (r_count == '0) begin
                        if (r_err == ST_OK) r_err <= ST_UNDERFLOW;
                        r_res   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_TOP_CAP;
                    end
                end
                S_TOP_CAP: begin
                    r_res   <= rd_data;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Wait for the output register to be free, then start afresh.
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res;
                        r_out_status <= r_err;
                        r_count      <= '0;
                        r_err        <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    pexp_stack #(
        .DEPTH (STACK_DEPTH),
        .W     (W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (cnt_m1[AW-1:0]),
        .o_rd_data (rd_data)
    );

    pexp_mul #(
        .W    (W),
        .FRAC (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_mul_req),
        .i_a      (r_op_a),
        .i_b      (r_op_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    pexp_div #(
        .W    (W),
        .FRAC (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_div_req),
        .i_num    (r_op_a),
        .i_den    (r_op_b),
        .o_done   (div_done),
        .o_result (div_res)
    );

    `PEXP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNTW'(STACK_DEPTH))
    `PEXP_ASSERT_IMP(a_mul_done_waits, mul_done, r_state == S_MUL_WAIT)
    `PEXP_ASSERT_IMP(a_div_done_waits, div_done, r_state == S_DIV_WAIT)
    `PEXP_ASSERT_IMP(a_write_not_full, wr_en, r_count < CNTW'(STACK_DEPTH))
    `PEXP_ASSERT_NXT(a_emit_loads, (r_state == S_EMIT) && (!r_out_valid || !i_stall), o_valid)

endmodule
